// ===== rtl/ic_pkg.sv =====
`default_nettype none

package ic_pkg;

	// fixed port widths
	localparam int VALUE_W = 32;
	localparam int INV_W   = 15;
	localparam int ELEM_W  = 9;

	// parameter defaults
	localparam int MAX_ELEMENTS_DEF = 256;
	localparam int VALUE_BITS_DEF   = 32;

	// control bits that travel with a packet along the chain
	typedef struct packed {
		logic valid;    // a packet is present on this link
		logic live;     // element is counted and compared
		logic pending;  // value not yet parked in a cell
		logic last;     // closes the sequence, clears cells it passes
	} ctl_t;

endpackage

`default_nettype wire

// ===== rtl/ic_cell.sv =====
`default_nettype none

module ic_cell #(
	parameter int VALUE_BITS = ic_pkg::VALUE_BITS_DEF,
	parameter int CNT_W      = 8
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  ic_pkg::ctl_t           in_ctl,
	input  wire [VALUE_BITS-1:0]   in_value,
	input  wire [CNT_W-1:0]        in_cnt,
	output ic_pkg::ctl_t           out_ctl,
	output logic [VALUE_BITS-1:0]  out_value,
	output logic [CNT_W-1:0]       out_cnt
);

	logic                  occ_q;
	logic [VALUE_BITS-1:0] stored_q;
	ic_pkg::ctl_t          ctl_q;
	logic [VALUE_BITS-1:0] value_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  hit;
	logic                  take;
	ic_pkg::ctl_t          ctl_next;

	// stored element greater than the passing one
	assign hit  = in_ctl.valid && in_ctl.live && occ_q && (stored_q > in_value);
	// first empty cell on the way parks the value
	assign take = in_ctl.valid && in_ctl.pending && !occ_q;

	always_comb begin
		ctl_next = in_ctl;
		if (take) begin
			ctl_next.pending = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
			ctl_q <= '0;
		end else begin
			ctl_q <= ctl_next;
			if (take) begin
				occ_q <= !in_ctl.last;
			end else if (in_ctl.valid && in_ctl.last) begin
				occ_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			stored_q <= in_value;
		end
		value_q <= in_value;
		cnt_q   <= in_cnt + CNT_W'(hit);
	end

	assign out_ctl   = ctl_q;
	assign out_value = value_q;
	assign out_cnt   = cnt_q;

endmodule

`default_nettype wire

// ===== rtl/ic_accum.sv =====
`default_nettype none

module ic_accum #(
	parameter int CNT_W  = 8,
	parameter int ELEM_B = 9
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  ic_pkg::ctl_t                 in_ctl,
	input  wire [CNT_W-1:0]              in_cnt,
	output logic                         done,
	output logic [ic_pkg::INV_W-1:0]     inversion_count,
	output logic [ic_pkg::ELEM_W-1:0]    element_count,
	output logic                         overflow
);

	localparam int INV_W = ic_pkg::INV_W;
	localparam int SUM_W = ((INV_W > CNT_W) ? INV_W : CNT_W) + 1;

	logic [INV_W-1:0]        acc_q;
	logic [ELEM_B-1:0]       elems_q;
	logic                    ovf_q;
	logic                    done_q;
	logic [INV_W-1:0]        inv_q;
	logic [ic_pkg::ELEM_W-1:0] elem_q;
	logic                    ovf_out_q;

	logic [SUM_W+INV_W-1:0]  acc_ext;
	logic [SUM_W+CNT_W-1:0]  cnt_ext;
	logic [SUM_W-1:0]        sum;
	logic [INV_W-1:0]        sat;
	logic [INV_W-1:0]        acc_next;
	logic [ELEM_B-1:0]       elems_next;
	logic                    ovf_next;
	logic [ELEM_B+ic_pkg::ELEM_W-1:0] elems_ext;

	assign acc_ext = {{SUM_W{1'b0}}, acc_q};
	assign cnt_ext = {{SUM_W{1'b0}}, in_cnt};
	assign sum     = acc_ext[SUM_W-1:0] + cnt_ext[SUM_W-1:0];
	// saturate at the widest inversion count
	assign sat     = (|sum[SUM_W-1:INV_W]) ? {INV_W{1'b1}} : sum[INV_W-1:0];

	always_comb begin
		acc_next   = acc_q;
		elems_next = elems_q;
		ovf_next   = ovf_q;
		if (in_ctl.valid) begin
			if (in_ctl.live) begin
				acc_next   = sat;
				elems_next = elems_q + ELEM_B'(1);
			end else begin
				ovf_next = 1'b1;
			end
		end
	end

	assign elems_ext = {{ic_pkg::ELEM_W{1'b0}}, elems_next};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			elems_q <= '0;
			ovf_q   <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= in_ctl.valid && in_ctl.last;
			if (in_ctl.valid && in_ctl.last) begin
				acc_q   <= '0;
				elems_q <= '0;
				ovf_q   <= 1'b0;
			end else begin
				acc_q   <= acc_next;
				elems_q <= elems_next;
				ovf_q   <= ovf_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ctl.valid && in_ctl.last) begin
			inv_q     <= acc_next;
			elem_q    <= elems_ext[ic_pkg::ELEM_W-1:0];
			ovf_out_q <= ovf_next;
		end
	end

	assign done            = done_q;
	assign inversion_count = inv_q;
	assign element_count   = elem_q;
	assign overflow        = ovf_out_q;

endmodule

`default_nettype wire

// ===== rtl/inversion_counter_top.sv =====
// channel   | ports                                          | handshake
// ----------+------------------------------------------------+---------------------------
// element   | value[31:0], last                              | start & !busy
// result    | inversion_count[14:0], element_count[8:0],     | done, one cycle, no stall
//           | overflow                                       |
//
// one element per cycle, back to back; busy stays low
// a result leaves once its last element has passed every cell of the chain and the accumulator's output register
// async reset empties every cell and the accumulator; cell contents need no clearing
// the receiver cannot stall: done is a one-cycle strobe
`default_nettype none

module inversion_counter_top #(
	parameter int MAX_ELEMENTS = ic_pkg::MAX_ELEMENTS_DEF,
	parameter int VALUE_BITS   = ic_pkg::VALUE_BITS_DEF
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             start,
	output logic                            busy,
	input  wire [ic_pkg::VALUE_W-1:0]       value,
	input  wire                             last,
	output logic                            done,
	output logic [ic_pkg::INV_W-1:0]        inversion_count,
	output logic [ic_pkg::ELEM_W-1:0]       element_count,
	output logic                            overflow
);

	// greater-than count per element never exceeds MAX_ELEMENTS - 1
	localparam int CNT_W  = (MAX_ELEMENTS > 2) ? $clog2(MAX_ELEMENTS) : 1;
	// fill count must hold MAX_ELEMENTS itself
	localparam int FILL_W = $clog2(MAX_ELEMENTS + 1);

	// ------------------------------------------------------------------
	// head: tracks how full the chain is for the current sequence
	// ------------------------------------------------------------------
	logic                 accept;
	logic                 full;
	logic [FILL_W-1:0]    fill_q;
	logic [VALUE_BITS+ic_pkg::VALUE_W-1:0] value_ext;

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign full   = (fill_q == FILL_W'(MAX_ELEMENTS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (accept) begin
			if (last) begin
				fill_q <= '0;
			end else if (!full) begin
				fill_q <= fill_q + FILL_W'(1);
			end
		end
	end

	// only the low VALUE_BITS bits take part, zero-extended if wider than the port
	assign value_ext = {{VALUE_BITS{1'b0}}, value};

	// ------------------------------------------------------------------
	// cell chain: each transaction walks one cell per cycle, counting
	// greater stored elements and parking its value in the first empty cell
	// ------------------------------------------------------------------
	ic_pkg::ctl_t          link_ctl   [MAX_ELEMENTS+1];
	logic [VALUE_BITS-1:0] link_value [MAX_ELEMENTS+1];
	logic [CNT_W-1:0]      link_cnt   [MAX_ELEMENTS+1];

	always_comb begin
		link_ctl[0].valid   = accept;
		link_ctl[0].live    = !full;   // an element past the limit is dropped
		link_ctl[0].pending = !full;
		link_ctl[0].last    = last;
	end
	assign link_value[0] = value_ext[VALUE_BITS-1:0];
	assign link_cnt[0]   = '0;

	for (genvar i = 0; i < MAX_ELEMENTS; i++) begin : g_cell
		ic_cell #(
			.VALUE_BITS (VALUE_BITS),
			.CNT_W      (CNT_W)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_ctl    (link_ctl[i]),
			.in_value  (link_value[i]),
			.in_cnt    (link_cnt[i]),
			.out_ctl   (link_ctl[i+1]),
			.out_value (link_value[i+1]),
			.out_cnt   (link_cnt[i+1])
		);
	end

	// ------------------------------------------------------------------
	// tail: sums per-element counts, counts elements, emits on last
	// ------------------------------------------------------------------
	ic_accum #(
		.CNT_W  (CNT_W),
		.ELEM_B (FILL_W)
	) u_accum (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_ctl          (link_ctl[MAX_ELEMENTS]),
		.in_cnt          (link_cnt[MAX_ELEMENTS]),
		.done            (done),
		.inversion_count (inversion_count),
		.element_count   (element_count),
		.overflow        (overflow)
	);

	// value leaving the far end of the chain is not needed
	logic unused_tail;
	assign unused_tail = ^link_value[MAX_ELEMENTS];

endmodule

`default_nettype wire
